>>> rtl/wfrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed frame rate statistics package
// Shared widths, register indexes, sequencer states and divider status.
// ----------------------------------------------------------------------------
package wfrs_pkg;

  localparam int TICK_W  = 32;
  localparam int DELTA_W = 24;
  localparam int RATE_W  = 16;
  localparam int HELD_W  = 9;
  localparam int FRAC_W  = 8;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int RATE_DIV_W = TICK_W + FRAC_W;

  localparam logic [IDX_W-1:0] REG_TICK_RATE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_RATE_FLOOR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_RATE_CEILING = 2'd2;

  localparam logic [TICK_W-1:0] TICK_RATE_RESET    = 32'd1000000;
  localparam logic [RATE_W-1:0] RATE_FLOOR_RESET   = 16'd256;
  localparam logic [RATE_W-1:0] RATE_CEILING_RESET = 16'd51200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_WRITE,
    ST_SCAN,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/wfrs_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; shared by the rate and mean divisions.
// ----------------------------------------------------------------------------
module wfrs_divider
  import wfrs_pkg::*;
#(
  parameter int N = 40,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient,
  output div_status_t  status
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     work;
  logic [D-1:0]     rem;
  logic [D-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D:0]       rem_shift;
  logic [D:0]       rem_diff;
  logic             qbit;

  always_comb begin
    rem_shift = {rem, work[N-1]};
    rem_diff  = rem_shift - {1'b0, dvs};
    qbit      = (rem_shift >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      work <= {work[N-2:0], qbit};
      rem  <= qbit ? rem_diff[D-1:0] : rem_shift[D-1:0];
    end
  end

  assign quotient    = work;
  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> rtl/wfrs_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate sample ring
// Single write port and one registered read port over the window samples.
// ----------------------------------------------------------------------------
module wfrs_ring
  import wfrs_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [RATE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [RATE_W-1:0] rd_data
);

  logic [RATE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/windowed_frame_rate_stats_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed frame rate statistics unit
// Converts frame intervals to clamped Q8.8 rates and reports window stats.
// ----------------------------------------------------------------------------
// Each transaction carries one frame interval in timer ticks. The unit
// computes floor(tick_rate * 256 / delta_ticks) with a serial divider (zero
// for a zero interval), clamps it to the ceiling and then the floor, stores
// it in a ring of WINDOW samples and reports the current rate with the
// minimum, maximum and truncated mean of the filled samples. The shared one
// bit per cycle divider runs for the rate, unless the interval is zero, and
// once for the mean, and the ring is read one sample per cycle through its
// single read port. The input is stalled while a transaction is in
// progress; a finished result waits in the output register while the next
// transaction is accepted.
// ----------------------------------------------------------------------------
module windowed_frame_rate_stats_unit
  import wfrs_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DELTA_W-1:0] delta_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RATE_W-1:0]  rate_now,
  output logic [RATE_W-1:0]  rate_mean,
  output logic [RATE_W-1:0]  rate_lowest,
  output logic [RATE_W-1:0]  rate_highest,
  output logic [HELD_W-1:0]  samples_held
);

  localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int SUM_W = RATE_W + CW;
  localparam int DIV_N = (SUM_W > RATE_DIV_W) ? SUM_W : RATE_DIV_W;
  localparam int DIV_D = (CW > DELTA_W) ? CW : DELTA_W;

  seq_state_t state;
  seq_state_t state_next;

  logic [TICK_W-1:0]  tick_rate;
  logic [RATE_W-1:0]  rate_floor;
  logic [RATE_W-1:0]  rate_ceiling;

  logic [DELTA_W-1:0] delta;
  logic [AW-1:0]      write_pos;
  logic [CW-1:0]      filled_count;
  logic [CW-1:0]      scan_idx;
  logic               pend;
  logic [SUM_W-1:0]   sum;
  logic [RATE_W-1:0]  lo;
  logic [RATE_W-1:0]  hi;
  logic [RATE_W-1:0]  rate_cur;

  logic               in_accept;
  logic               out_free;
  logic               div_start;
  logic [DIV_N-1:0]   div_dividend;
  logic [DIV_D-1:0]   div_divisor;
  logic [DIV_N-1:0]   div_quotient;
  div_status_t        div_status;
  logic [DIV_N-1:0]   raw_rate;
  logic [RATE_W-1:0]  rate_clamped;
  logic               rd_en;
  logic [RATE_W-1:0]  rd_data;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign rd_en     = (state == ST_SCAN) && (scan_idx < filled_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate    <= TICK_RATE_RESET;
      rate_floor   <= RATE_FLOOR_RESET;
      rate_ceiling <= RATE_CEILING_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TICK_RATE:    tick_rate    <= cfg_data;
        REG_RATE_FLOOR:   rate_floor   <= cfg_data[RATE_W-1:0];
        REG_RATE_CEILING: rate_ceiling <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_N'(sum);
    div_divisor  = DIV_D'(filled_count);
    if (state == ST_RATE_START) begin
      div_start    = (delta != '0);
      div_dividend = DIV_N'({tick_rate, FRAC_W'(0)});
      div_divisor  = DIV_D'(delta);
    end else if (state == ST_MEAN_START) begin
      div_start = 1'b1;
    end
  end

  wfrs_divider #(
    .N (DIV_N),
    .D (DIV_D)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .status   (div_status)
  );

  always_comb begin
    raw_rate = (delta == '0) ? '0 : div_quotient;
    if (raw_rate > DIV_N'(rate_ceiling)) begin
      rate_clamped = rate_ceiling;
    end else begin
      rate_clamped = raw_rate[RATE_W-1:0];
    end
    if (rate_clamped < rate_floor) begin
      rate_clamped = rate_floor;
    end
  end

  wfrs_ring #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state == ST_WRITE),
    .wr_addr (write_pos),
    .wr_data (rate_clamped),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_RATE_START;
        end
      end
      ST_RATE_START: begin
        state_next = (delta == '0) ? ST_WRITE : ST_RATE_WAIT;
      end
      ST_RATE_WAIT: begin
        if (div_status.done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!rd_en && !pend) begin
          state_next = ST_MEAN_START;
        end
      end
      ST_MEAN_START: begin
        state_next = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        if (div_status.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos    <= '0;
      filled_count <= '0;
      scan_idx     <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      pend <= rd_en;
      if (rd_en) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (state == ST_WRITE) begin
        scan_idx  <= '0;
        write_pos <= (write_pos == AW'(WINDOW - 1)) ? '0 : write_pos + 1'b1;
        if (filled_count != CW'(WINDOW)) begin
          filled_count <= filled_count + 1'b1;
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      delta <= delta_ticks;
    end
    if (state == ST_WRITE) begin
      rate_cur <= rate_clamped;
      sum      <= '0;
      lo       <= '1;
      hi       <= '0;
    end else if (pend) begin
      sum <= sum + SUM_W'(rd_data);
      if (rd_data < lo) begin
        lo <= rd_data;
      end
      if (rd_data > hi) begin
        hi <= rd_data;
      end
    end
    if (state == ST_DONE && out_free) begin
      rate_now     <= rate_cur;
      rate_mean    <= div_quotient[RATE_W-1:0];
      rate_lowest  <= lo;
      rate_highest <= hi;
      samples_held <= HELD_W'(filled_count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    filled_count <= CW'(WINDOW))
    else $error("fill count exceeds the window depth");

  a_pos_tracks_count: assert property (@(posedge clk) disable iff (rst)
    (filled_count < CW'(WINDOW)) |-> (CW'(write_pos) == filled_count))
    else $error("write position out of step with the fill count");

  a_min_max_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rate_lowest <= rate_highest))
    else $error("window minimum above maximum");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rate_mean >= rate_lowest && rate_mean <= rate_highest))
    else $error("window mean outside the minimum to maximum range");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider started while still busy");

endmodule

>>> tb/frame_rate_stats_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate statistics checker
// Watches the register port and both channels of the windowed frame rate
// statistics unit, keeps its own copy of the rate window, predicts the
// statistics of every accepted interval and compares them with the results.
// ----------------------------------------------------------------------------
module frame_rate_stats_checker
  import wfrs_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DELTA_W-1:0] delta_ticks,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [RATE_W-1:0]  rate_now,
  input  logic [RATE_W-1:0]  rate_mean,
  input  logic [RATE_W-1:0]  rate_lowest,
  input  logic [RATE_W-1:0]  rate_highest,
  input  logic [HELD_W-1:0]  samples_held,
  output int                 fault_count,
  output int                 outstanding
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef struct packed {
    logic [RATE_W-1:0] now;
    logic [RATE_W-1:0] mean;
    logic [RATE_W-1:0] lowest;
    logic [RATE_W-1:0] highest;
    logic [HELD_W-1:0] held;
  } frame_stats_t;

  logic [TICK_W-1:0] ticks_per_sec;
  logic [RATE_W-1:0] floor_q88;
  logic [RATE_W-1:0] ceiling_q88;
  logic [RATE_W-1:0] rate_hist [WINDOW];
  int unsigned       next_slot;
  int unsigned       slots_filled;
  frame_stats_t      stats_due [$];

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [DELTA_W-1:0] interval);
    logic [RATE_DIV_W-1:0] quotient;
    logic [RATE_DIV_W-1:0] divisor;
    logic [RATE_DIV_W-1:0] upper;
    logic [RATE_DIV_W-1:0] lower;
    quotient = '0;
    divisor = RATE_DIV_W'(interval);
    upper = RATE_DIV_W'(ceiling_q88);
    lower = RATE_DIV_W'(floor_q88);
    if (interval != '0) begin
      quotient = {ticks_per_sec, {FRAC_W{1'b0}}} / divisor;
    end
    if (quotient > upper) begin
      quotient = upper;
    end
    if (quotient < lower) begin
      quotient = lower;
    end
    return quotient[RATE_W-1:0];
  endfunction

  function automatic frame_stats_t record_interval(input logic [DELTA_W-1:0] interval);
    frame_stats_t      s;
    logic [RATE_W-1:0] r;
    logic [RATE_W-1:0] v;
    longint unsigned   total;
    longint unsigned   avg;
    int unsigned       k;
    r = clamp_rate(interval);
    rate_hist[SLOT_W'(next_slot)] = r;
    next_slot = (next_slot + 1) % WINDOW;
    if (slots_filled < WINDOW) begin
      slots_filled++;
    end
    total = 0;
    s.lowest = '1;
    s.highest = '0;
    for (k = 0; k < slots_filled; k++) begin
      v = rate_hist[SLOT_W'(k)];
      total += v;
      if (v < s.lowest) begin
        s.lowest = v;
      end
      if (v > s.highest) begin
        s.highest = v;
      end
    end
    avg = total / slots_filled;
    s.now = r;
    s.mean = avg[RATE_W-1:0];
    s.held = slots_filled[HELD_W-1:0];
    return s;
  endfunction

  task automatic check_field(input string field, input logic [RATE_W-1:0] want,
                             input logic [RATE_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_stats_t want;
    if (rst) begin
      ticks_per_sec = TICK_RATE_RESET;
      floor_q88 = RATE_FLOOR_RESET;
      ceiling_q88 = RATE_CEILING_RESET;
      next_slot = 0;
      slots_filled = 0;
      stats_due.delete();
      fault_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TICK_RATE: begin
            ticks_per_sec = cfg_data;
          end
          REG_RATE_FLOOR: begin
            floor_q88 = cfg_data[RATE_W-1:0];
          end
          REG_RATE_CEILING: begin
            ceiling_q88 = cfg_data[RATE_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        stats_due.push_back(record_interval(delta_ticks));
      end
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $error("Result transaction arrived with no interval outstanding.");
          fault_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("rate_now", want.now, rate_now);
          check_field("rate_mean", want.mean, rate_mean);
          check_field("rate_lowest", want.lowest, rate_lowest);
          check_field("rate_highest", want.highest, rate_highest);
          check_field("samples_held", {{(RATE_W-HELD_W){1'b0}}, want.held},
                      {{(RATE_W-HELD_W){1'b0}}, samples_held});
        end
      end
    end
    outstanding = stats_due.size();
  end

endmodule

>>> tb/windowed_frame_rate_stats_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed frame rate statistics unit testbench
// Drives frame intervals and register settings into the unit with random
// gaps and output stalls, first a directed set of corner cases and then
// several phases of random intervals under different rate settings. The
// checker beside the unit predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module windowed_frame_rate_stats_unit_test;
  import wfrs_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int IDLE_PCT     = 31;
  localparam int SETTLE_TICKS = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 118;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DELTA_W-1:0] delta_ticks = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RATE_W-1:0]  rate_now;
  logic [RATE_W-1:0]  rate_mean;
  logic [RATE_W-1:0]  rate_lowest;
  logic [RATE_W-1:0]  rate_highest;
  logic [HELD_W-1:0]  samples_held;
  int                 fault_count;
  int                 outstanding;
  logic               steady = 1'b0;

  windowed_frame_rate_stats_unit dut (.*);

  frame_rate_stats_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic push_interval(input logic [DELTA_W-1:0] interval);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    delta_ticks <= interval;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  function automatic logic [DELTA_W-1:0] pick_interval();
    logic [31:0] r;
    int unsigned span;
    r = $urandom();
    if ($urandom_range(99) < 5) begin
      r = '0;
    end else if ($urandom_range(99) < 80) begin
      span = $urandom_range(DELTA_W - 1, 1);
      r = r & ((32'd1 << span) - 32'd1);
    end
    return r[DELTA_W-1:0];
  endfunction

  task automatic pick_settings(input int phase);
    logic [CFG_W-1:0] ticks;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    case ($urandom_range(4))
      0: ticks = TICK_RATE_RESET;
      1: ticks = $urandom();
      2: ticks = $urandom_range(65535, 1);
      3: ticks = '0;
      default: ticks = '1;
    endcase
    case ($urandom_range(3))
      0: begin
        lo = '0;
        hi = 32'h0000_FFFF;
      end
      1: begin
        lo = $urandom_range(65535);
        hi = $urandom_range(65535);
      end
      default: begin
        lo = $urandom_range(2000);
        hi = $urandom_range(65535, lo);
      end
    endcase
    if (phase == 0) begin
      ticks = TICK_RATE_RESET;
      lo = {16'd0, RATE_FLOOR_RESET};
      hi = {16'd0, RATE_CEILING_RESET};
    end else if (phase == 1) begin
      ticks = TICK_RATE_RESET;
      lo = '0;
      hi = 32'h0000_FFFF;
    end
    write_reg(REG_TICK_RATE, ticks);
    write_reg(REG_RATE_FLOOR, lo);
    write_reg(REG_RATE_CEILING, hi);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero interval, shortest and longest, saturated rates.
    push_interval(24'd0);
    push_interval(24'd1);
    push_interval(24'hFFFFFF);
    push_interval(24'd1000000);
    push_interval(24'd3906);
    push_interval(24'd20000);
    drain_results(8);

    // A zero tick rate gives a zero raw rate; the spare index is ignored.
    write_reg(REG_TICK_RATE, 32'd0);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    push_interval(24'd1234);
    push_interval(24'd0);
    drain_results(8);

    write_reg(REG_RATE_FLOOR, 32'd0);
    push_interval(24'd0);
    push_interval(24'd5);
    drain_results(8);

    // Quotients beyond sixteen bits saturate at the ceiling.
    write_reg(REG_TICK_RATE, 32'hFFFF_FFFF);
    write_reg(REG_RATE_CEILING, 32'h0000_FFFF);
    push_interval(24'd1);
    push_interval(24'hFFFFFF);
    push_interval(24'h800000);
    push_interval(24'h00FFFF);
    drain_results(8);

    // With the floor above the ceiling the floor wins.
    write_reg(REG_RATE_FLOOR, 32'h0000_8000);
    write_reg(REG_RATE_CEILING, 32'h0000_0100);
    push_interval(24'd7);
    push_interval(24'd0);
    push_interval(24'hFFFFFF);
    drain_results(8);

    for (int phase = 0; phase < PHASES; phase++) begin
      pick_settings(phase);
      steady <= (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_interval(pick_interval());
        if (phase == 5 && n == 60) begin
          drain_results(0);
        end
      end
      drain_results(8);
      steady <= 1'b0;
    end

    drain_results(SETTLE_TICKS);
    if (fault_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
